FILE: hw/rtl/mpq_pkg.sv
package mpq_pkg;

  localparam int NODE_COUNT  = 256;
  localparam int NODE_BITS   = 8;
  localparam int WEIGHT_BITS = 32;
  localparam int COUNT_BITS  = 9;

  localparam logic [2:0] FUNC_INSERT   = 3'd0;
  localparam logic [2:0] FUNC_DECREASE = 3'd1;
  localparam logic [2:0] FUNC_QUERY    = 3'd2;
  localparam logic [2:0] FUNC_EXTRACT  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR    = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  typedef enum logic [2:0] {
    OP_INS, OP_DEC, OP_QRY, OP_EXT, OP_CLR, OP_BAD
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [NODE_BITS-1:0]   node;
    logic [WEIGHT_BITS-1:0] weight;
  } req_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]   node;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   present;
    logic [1:0]             status;
    logic [COUNT_BITS-1:0]  occupancy;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_SCAN, S_PUSH
  } state_t;

endpackage

FILE: hw/rtl/mpq_front.sv
module mpq_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_func,
  input  logic [mpq_pkg::NODE_BITS-1:0]  in_node,
  input  logic [mpq_pkg::WEIGHT_BITS-1:0] in_weight,
  output logic                           q_valid,
  output mpq_pkg::req_t                  q_req,
  input  logic                           q_pop
);
  import mpq_pkg::*;

  req_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  req_t       cls;
  logic       push;

  always_comb begin
    cls.node   = in_node;
    cls.weight = in_weight;
    unique case (in_func)
      FUNC_INSERT:   cls.op = OP_INS;
      FUNC_DECREASE: cls.op = OP_DEC;
      FUNC_QUERY:    cls.op = OP_QRY;
      FUNC_EXTRACT:  cls.op = OP_EXT;
      FUNC_CLEAR:    cls.op = OP_CLR;
      default:       cls.op = OP_BAD;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

FILE: hw/rtl/mpq_back.sv
module mpq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  mpq_pkg::req_t q_req,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output mpq_pkg::res_t out_res
);
  import mpq_pkg::*;

  state_t                 state_r, state_nxt;
  logic [NODE_COUNT-1:0]  valid_r;
  logic [WEIGHT_BITS-1:0] mem [NODE_COUNT];
  logic [WEIGHT_BITS-1:0] rdata_r;
  logic [NODE_BITS-1:0]   raddr;
  logic [COUNT_BITS-1:0]  count_r;
  logic [NODE_BITS-1:0]   best_node_r;
  logic [WEIGHT_BITS-1:0] best_w_r;
  logic                   found_r;
  logic [COUNT_BITS-1:0]  scan_r;
  logic                   pend_r, pend_v_r;
  logic [NODE_BITS-1:0]   pend_idx_r;
  req_t                   cur_r;
  res_t                   res_r;
  res_t                   res_nxt;
  logic                   out_valid_r;
  logic                   have, scan_end, slot_free, hit, take;

  assign have      = valid_r[q_req.node];
  assign scan_end  = scan_r[COUNT_BITS-1];
  assign slot_free = !out_valid_r || out_ready;
  assign take      = (state_r == S_IDLE) && q_valid && slot_free;
  assign hit       = pend_r && pend_v_r && (!found_r || rdata_r < best_w_r);
  assign raddr     = (state_r == S_SCAN) ? scan_r[NODE_BITS-1:0] : q_req.node;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:
        if (take) begin
          if (q_req.op == OP_DEC && have) state_nxt = S_DEC;
          else if (q_req.op == OP_EXT && count_r != '0) state_nxt = S_SCAN;
          else state_nxt = S_PUSH;
        end
      S_DEC:  state_nxt = S_PUSH;
      S_SCAN: if (scan_end && !pend_r) state_nxt = S_PUSH;
      S_PUSH: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = take;
    out_valid = out_valid_r;
    out_res   = res_r;
  end

  always_comb begin
    res_nxt           = '0;
    res_nxt.occupancy = count_r;
    case (q_req.op)
      OP_INS: begin
        res_nxt.present = 1'b1;
        if (have) res_nxt.status = ST_IGNORED;
        else res_nxt.occupancy = count_r + 1'b1;
      end
      OP_DEC: begin
        res_nxt.present = have;
        if (!have) res_nxt.status = ST_IGNORED;
      end
      OP_QRY: res_nxt.present = have;
      OP_EXT:
        if (count_r == '0) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          res_nxt.node   = best_node_r;
          res_nxt.weight = best_w_r;
          if (valid_r[best_node_r]) res_nxt.occupancy = count_r - 1'b1;
        end
      OP_CLR: res_nxt.occupancy = '0;
      default: res_nxt.status = ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (take && q_req.op == OP_INS && !have)
      mem[q_req.node] <= q_req.weight;
    if (state_r == S_DEC && cur_r.weight < rdata_r)
      mem[cur_r.node] <= cur_r.weight;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      best_node_r <= '0;
      best_w_r    <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_PUSH && slot_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE:
          if (take) begin
            cur_r <= q_req;
            res_r <= res_nxt;
            case (q_req.op)
              OP_INS:
                if (!have) begin
                  valid_r[q_req.node] <= 1'b1;
                  count_r             <= count_r + 1'b1;
                  if (count_r == '0 || q_req.weight < best_w_r) begin
                    best_w_r    <= q_req.weight;
                    best_node_r <= q_req.node;
                  end
                end
              OP_EXT:
                if (count_r != '0) begin
                  if (valid_r[best_node_r]) begin
                    valid_r[best_node_r] <= 1'b0;
                    count_r              <= count_r - 1'b1;
                  end
                  best_node_r <= '0;
                  best_w_r    <= '0;
                  found_r     <= 1'b0;
                  scan_r      <= '0;
                  pend_r      <= 1'b0;
                end
              OP_CLR: begin
                valid_r     <= '0;
                count_r     <= '0;
                best_node_r <= '0;
                best_w_r    <= '0;
              end
              default: ;
            endcase
          end
        S_DEC:
          if (cur_r.weight < rdata_r) begin
            if (cur_r.weight < best_w_r) begin
              best_w_r    <= cur_r.weight;
              best_node_r <= cur_r.node;
            end
          end else begin
            res_r.status <= ST_IGNORED;
          end
        S_SCAN: begin
          pend_r     <= !scan_end;
          pend_idx_r <= scan_r[NODE_BITS-1:0];
          pend_v_r   <= valid_r[scan_r[NODE_BITS-1:0]];
          if (!scan_end) scan_r <= scan_r + 1'b1;
          if (hit) begin
            best_w_r    <= rdata_r;
            best_node_r <= pend_idx_r;
            found_r     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: hw/rtl/min_priority_queue_decrease_key.sv
// channel | handshake          | payload
// in      | in_valid/in_ready   | in_func, in_node, in_weight
// out     | out_valid/out_ready | out_node, out_weight, out_present, out_status, out_occupancy
// Insert, query, clear and ignored codes go from S_IDLE to S_PUSH; decrease-key of a present node passes S_DEC first.
// Extract on a non-empty queue rescans the weight memory through its single read port, one node a cycle.
// Reset clears all valid bits at once; no clearing pass is needed.
// A two-request queue decouples the input from the executing back end; the back end
// holds its result until taken and starts the next request as the result leaves.
module min_priority_queue_decrease_key (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      in_func,
  input  logic [mpq_pkg::NODE_BITS-1:0]   in_node,
  input  logic [mpq_pkg::WEIGHT_BITS-1:0] in_weight,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mpq_pkg::NODE_BITS-1:0]   out_node,
  output logic [mpq_pkg::WEIGHT_BITS-1:0] out_weight,
  output logic                            out_present,
  output logic [1:0]                      out_status,
  output logic [mpq_pkg::COUNT_BITS-1:0]  out_occupancy
);
  import mpq_pkg::*;

  logic q_valid, q_pop;
  req_t q_req;
  res_t res;

  mpq_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_node, .in_weight,
    .q_valid, .q_req, .q_pop
  );

  mpq_back u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_pop, .out_valid, .out_ready, .out_res(res)
  );

  assign out_node      = res.node;
  assign out_weight    = res.weight;
  assign out_present   = res.present;
  assign out_status    = res.status;
  assign out_occupancy = res.occupancy;
endmodule

FILE: hw/rtl/mpq_checker.sv
module mpq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [mpq_pkg::NODE_BITS-1:0]   out_node,
  input logic [mpq_pkg::WEIGHT_BITS-1:0] out_weight,
  input logic                            out_present,
  input logic [1:0]                      out_status,
  input logic [mpq_pkg::COUNT_BITS-1:0]  out_occupancy
);
  import mpq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_node))
    else $error("result dropped while stalled");

  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= 9'd256)
    else $error("occupancy out of range");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_node == '0 && out_weight == '0 && !out_present && out_occupancy == '0)
    else $error("empty extract result malformed");
endmodule

bind min_priority_queue_decrease_key mpq_checker u_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_node, .out_weight, .out_present,
  .out_status, .out_occupancy
);
